// File: hdl/uartrx_pkg.sv
// shared constants, op codes and index helper for the uart receive line buffer
package uartrx_pkg;

    localparam int DEPTH    = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int BYTE_W   = 8;
    localparam int LINES_W  = 8;
    localparam int MAX_LINE = 31;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);

    localparam logic [1:0] OP_RECV    = 2'd0;
    localparam logic [1:0] OP_BYTE    = 2'd1;
    localparam logic [1:0] OP_LINE    = 2'd2;
    localparam logic [1:0] OP_DISCARD = 2'd3;

    localparam logic [BYTE_W-1:0] CHAR_CR = 8'd13;
    localparam logic [BYTE_W-1:0] CHAR_LF = 8'd10;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] i);
        logic [IDX_W-1:0] n;
        if (i == IDX_W'(DEPTH - 1))
        begin
            n = '0;
        end
        else
        begin
            n = i + 1'b1;
        end
        return n;
    endfunction

endpackage

// File: hdl/uartrx_ram.sv
// generic single write port ram with registered read
module uartrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/uart_rx_line_ring_buffer.sv
// uart receive ring buffer with line assembly: control, output register, ring ram
// Usage:
//   input channel (in_valid/in_stall) carries op and rx_byte; output channel
//   (out_valid/out_stall) carries data, valid_res, last and lines_count.
//   op receive stores a byte (zero dropped, CR becomes LF, repeated LF dropped);
//   op read byte returns one byte or an empty result; op read line returns the
//   bytes of one line followed by an end result; op discard empties the ring
//   while a line is pending. Every transaction ends with a result with last set.
// Sequencing:
//   receive, discard, empty read and read line with no pending line: the result
//   is loaded into the output register when the transaction is accepted.
//   read byte: the ring ram read is registered, then the fetch state loads the byte.
//   read line: the fetch state loads each emitted byte and consumes a stop byte,
//   then the end state loads the end result; each byte is one ram read.
//   one transaction is worked on at a time; the next is accepted once the
//   previous one has produced all its results and the output register is free.
// Reset: indexes, pending line count and newline flag clear; ring contents are
//   left as they are and no clearing pass runs.
// Stall: while out_stall holds and a result is held, the output register keeps it and the
//   block stops taking new input and stops reading the ring.
module uart_rx_line_ring_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          op,
    input  logic [uartrx_pkg::BYTE_W-1:0]       rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [uartrx_pkg::BYTE_W-1:0]       data,
    output logic                                valid_res,
    output logic                                last,
    output logic [uartrx_pkg::LINES_W-1:0]      lines_count
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_FETCH = 3'b010,
        ST_END   = 3'b100
    } state_t;

    state_t                               state_reg, state_next;
    logic                                 line_mode_reg, line_mode_next;
    logic [uartrx_pkg::IDX_W-1:0]         wr_idx_reg, wr_idx_next;
    logic [uartrx_pkg::IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic [uartrx_pkg::LINES_W-1:0]       pend_reg, pend_next;
    logic                                 nl_seen_reg, nl_seen_next;
    logic [uartrx_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    logic                                 out_valid_reg, out_valid_next;
    logic [uartrx_pkg::BYTE_W-1:0]        data_reg, data_next;
    logic                                 vres_reg, vres_next;
    logic                                 last_reg, last_next;
    logic [uartrx_pkg::LINES_W-1:0]       lines_reg, lines_next;

    logic                                 ram_we;
    logic                                 ram_re;
    logic [uartrx_pkg::IDX_W-1:0]         ram_raddr;
    logic [uartrx_pkg::BYTE_W-1:0]        ram_rdata;

    logic                                 accept;
    logic                                 out_free;
    logic                                 load;
    logic [uartrx_pkg::BYTE_W-1:0]        ld_data;
    logic                                 ld_vres;
    logic                                 ld_last;

    logic [uartrx_pkg::BYTE_W-1:0]        rx_mapped;
    logic                                 rx_is_lf;
    logic                                 rx_drop;
    logic [uartrx_pkg::IDX_W-1:0]         slot;
    logic                                 rx_full;
    logic [uartrx_pkg::IDX_W-1:0]         rd_nxt;
    logic                                 ring_empty;
    logic                                 stop_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    assign rx_mapped  = (rx_byte == uartrx_pkg::CHAR_CR) ? uartrx_pkg::CHAR_LF : rx_byte;
    assign rx_is_lf   = (rx_mapped == uartrx_pkg::CHAR_LF);
    assign rx_drop    = (rx_byte == '0) || (rx_is_lf && nl_seen_reg);
    assign slot       = uartrx_pkg::next_slot(wr_idx_reg);
    assign rx_full    = (uartrx_pkg::next_slot(slot) == rd_idx_reg);
    assign rd_nxt     = uartrx_pkg::next_slot(rd_idx_reg);
    assign ring_empty = (rd_idx_reg == wr_idx_reg);
    assign ram_raddr  = rd_nxt;
    // newline, high byte and zero end a line and are consumed
    assign stop_byte  = (ram_rdata == uartrx_pkg::CHAR_LF) || ram_rdata[uartrx_pkg::BYTE_W-1]
                        || (ram_rdata == '0);

    uartrx_ram #(
        .WIDTH (uartrx_pkg::BYTE_W),
        .DEPTH (uartrx_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (rx_mapped),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        line_mode_next = line_mode_reg;
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        pend_next      = pend_reg;
        nl_seen_next   = nl_seen_reg;
        cnt_next       = cnt_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        load           = 1'b0;
        ld_data        = '0;
        ld_vres        = 1'b0;
        ld_last        = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        uartrx_pkg::OP_RECV:
                        begin
                            load = 1'b1;
                            if (!rx_drop)
                            begin
                                ram_we       = 1'b1;
                                wr_idx_next  = slot;
                                nl_seen_next = rx_is_lf;
                                // a newline and a full ring each count as a line
                                pend_next    = pend_reg + uartrx_pkg::LINES_W'(rx_is_lf)
                                               + uartrx_pkg::LINES_W'(rx_full);
                            end
                        end
                        uartrx_pkg::OP_BYTE:
                        begin
                            if (ring_empty)
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                ram_re         = 1'b1;
                                rd_idx_next    = rd_nxt;
                                line_mode_next = 1'b0;
                                state_next     = ST_FETCH;
                            end
                        end
                        uartrx_pkg::OP_LINE:
                        begin
                            if (pend_reg == '0)
                            begin
                                load = 1'b1;
                            end
                            else
                            begin
                                cnt_next       = '0;
                                line_mode_next = 1'b1;
                                if (ring_empty)
                                begin
                                    state_next = ST_END;
                                end
                                else
                                begin
                                    ram_re      = 1'b1;
                                    rd_idx_next = rd_nxt;
                                    state_next  = ST_FETCH;
                                end
                            end
                        end
                        default:
                        begin
                            load = 1'b1;
                            if (pend_reg != '0)
                            begin
                                rd_idx_next = wr_idx_reg;
                            end
                        end
                    endcase
                end
            end
            ST_FETCH:
            begin
                if (out_free)
                begin
                    if (!line_mode_reg)
                    begin
                        load       = 1'b1;
                        ld_data    = ram_rdata;
                        ld_vres    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (stop_byte)
                    begin
                        state_next = ST_END;
                    end
                    else
                    begin
                        load     = 1'b1;
                        ld_data  = ram_rdata;
                        ld_vres  = 1'b1;
                        ld_last  = 1'b0;
                        cnt_next = cnt_reg + 1'b1;
                        if ((cnt_reg == uartrx_pkg::CNT_W'(uartrx_pkg::MAX_LINE - 1))
                            || ring_empty)
                        begin
                            state_next = ST_END;
                        end
                        else
                        begin
                            ram_re      = 1'b1;
                            rd_idx_next = rd_nxt;
                        end
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    pend_next  = pend_reg - 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        data_next      = data_reg;
        vres_next      = vres_reg;
        last_next      = last_reg;
        lines_next     = lines_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            data_next      = ld_data;
            vres_next      = ld_vres;
            last_next      = ld_last;
            lines_next     = pend_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            line_mode_reg <= 1'b0;
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= '0;
            nl_seen_reg   <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_mode_reg <= line_mode_next;
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            pend_reg      <= pend_next;
            nl_seen_reg   <= nl_seen_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        vres_reg  <= vres_next;
        last_reg  <= last_next;
        lines_reg <= lines_next;
    end

    assign out_valid   = out_valid_reg;
    assign data        = data_reg;
    assign valid_res   = vres_reg;
    assign last        = last_reg;
    assign lines_count = lines_reg;

`ifndef NO_ASSERTIONS
    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall)
        else $error("input taken while a transaction is in progress");

    a_read_to_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        ram_re |=> state_reg == ST_FETCH)
        else $error("ring read issued without fetch state following");

    a_line_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) && line_mode_reg
        |-> cnt_reg < uartrx_pkg::CNT_W'(uartrx_pkg::MAX_LINE))
        else $error("line read emitted too many bytes");

    a_empty_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !vres_reg |-> (data_reg == '0) && last_reg)
        else $error("status result carries data or is not last");
`endif

endmodule

// File: tb/tb_uart_rx_line_ring_buffer.sv
// self-checking testbench for the uart receive line ring buffer
module tb_uart_rx_line_ring_buffer;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 230;
    localparam int CALM_TAIL   = 25;

    typedef struct {
        logic [1:0]                    code;
        logic [uartrx_pkg::BYTE_W-1:0] ch;
        bit                            drain;
    } rx_txn_t;

    typedef struct {
        logic [uartrx_pkg::BYTE_W-1:0]  data;
        logic                           valid_res;
        logic                           last;
        logic [uartrx_pkg::LINES_W-1:0] lines_count;
    } ring_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [1:0]                      op = uartrx_pkg::OP_RECV;
    logic [uartrx_pkg::BYTE_W-1:0]   rx_byte = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [uartrx_pkg::BYTE_W-1:0]   data;
    logic                            valid_res;
    logic                            last;
    logic [uartrx_pkg::LINES_W-1:0]  lines_count;

    // predicted buffer state
    logic [uartrx_pkg::BYTE_W-1:0]   ring_copy [uartrx_pkg::DEPTH];
    logic [uartrx_pkg::IDX_W-1:0]    wr_ptr = '0;
    logic [uartrx_pkg::IDX_W-1:0]    rd_ptr = '0;
    logic [uartrx_pkg::LINES_W-1:0]  lines_pending = '0;
    logic                            lf_stored = 1'b0;

    rx_txn_t             pending_txns [$];
    ring_result_t        results_due [$];

    int                  errors = 0;
    int                  queued = 0;
    int                  accepted = 0;
    int                  checked = 0;
    int                  lines_read = 0;
    int                  ring_full_hits = 0;
    int                  overruns = 0;
    int                  cycles = 0;
    int                  send_gap = 0;
    int                  send_rate = 2;
    int                  stall_left = 0;
    int                  stall_rate = 2;
    bit                  calm = 1'b0;

    uart_rx_line_ring_buffer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data        (data),
        .valid_res   (valid_res),
        .last        (last),
        .lines_count (lines_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [uartrx_pkg::IDX_W-1:0] ring_step(
        input logic [uartrx_pkg::IDX_W-1:0] i);
        return uartrx_pkg::IDX_W'((int'(i) + 1) % uartrx_pkg::DEPTH);
    endfunction

    function automatic void expect_result(input logic [uartrx_pkg::BYTE_W-1:0] d,
                                          input logic v, input logic l);
        ring_result_t r;
        r.data        = d;
        r.valid_res   = v;
        r.last        = l;
        r.lines_count = lines_pending;
        results_due.push_back(r);
    endfunction

    // applies one transaction to the predicted state and queues its results
    function automatic void buffer_op_outcome(input logic [1:0] code,
                                              input logic [uartrx_pkg::BYTE_W-1:0] rx);
        logic [uartrx_pkg::BYTE_W-1:0] c;
        logic [uartrx_pkg::IDX_W-1:0]  slot;
        int                            n;
        bit                            stop;
        bit                            answered;
        n = 0;
        stop = 1'b0;
        answered = 1'b0;
        c = rx;
        case (code)
            uartrx_pkg::OP_RECV:
            begin
                if (c == uartrx_pkg::CHAR_CR)
                begin
                    c = uartrx_pkg::CHAR_LF;
                end
                // zero bytes and a second newline in a row are dropped
                if (c != '0 && !(c == uartrx_pkg::CHAR_LF && lf_stored))
                begin
                    if (c == uartrx_pkg::CHAR_LF)
                    begin
                        lf_stored = 1'b1;
                        lines_pending = lines_pending + 1'b1;
                    end
                    else
                    begin
                        lf_stored = 1'b0;
                    end
                    slot = ring_step(wr_ptr);
                    if (slot == rd_ptr)
                    begin
                        overruns++;
                    end
                    wr_ptr = slot;
                    ring_copy[slot] = c;
                    if (ring_step(slot) == rd_ptr)
                    begin
                        lines_pending = lines_pending + 1'b1;
                        ring_full_hits++;
                    end
                end
            end
            uartrx_pkg::OP_BYTE:
            begin
                if (rd_ptr != wr_ptr)
                begin
                    rd_ptr = ring_step(rd_ptr);
                    expect_result(ring_copy[rd_ptr], 1'b1, 1'b1);
                    answered = 1'b1;
                end
            end
            uartrx_pkg::OP_LINE:
            begin
                if (lines_pending != '0)
                begin
                    while (!stop && n < uartrx_pkg::MAX_LINE && rd_ptr != wr_ptr)
                    begin
                        rd_ptr = ring_step(rd_ptr);
                        c = ring_copy[rd_ptr];
                        // stop byte is consumed but not emitted
                        if (c == uartrx_pkg::CHAR_LF || c[uartrx_pkg::BYTE_W-1] || c == '0)
                        begin
                            stop = 1'b1;
                        end
                        else
                        begin
                            expect_result(c, 1'b1, 1'b0);
                            n++;
                        end
                    end
                    lines_pending = lines_pending - 1'b1;
                    lines_read++;
                end
            end
            default:
            begin
                if (lines_pending != '0)
                begin
                    rd_ptr = wr_ptr;
                end
            end
        endcase
        if (!answered)
        begin
            expect_result('0, 1'b0, 1'b1);
        end
    endfunction

    task automatic queue_txn(input logic [1:0] code,
                             input logic [uartrx_pkg::BYTE_W-1:0] c, input bit drain);
        rx_txn_t t;
        t.code  = code;
        t.ch    = c;
        t.drain = drain;
        pending_txns.push_back(t);
        queued++;
    endtask

    task automatic queue_text_line(input int len, input int term);
        logic [uartrx_pkg::BYTE_W-1:0] c;
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 19))
                0:       c = '0;
                1:       c = uartrx_pkg::CHAR_CR;
                2:       c = uartrx_pkg::BYTE_W'($urandom_range(128, 255));
                3, 4:    c = uartrx_pkg::BYTE_W'($urandom_range(0, 255));
                default: c = uartrx_pkg::BYTE_W'($urandom_range(8'h20, 8'h7e));
            endcase
            queue_txn(uartrx_pkg::OP_RECV, c, $urandom_range(0, 39) == 0);
        end
        case (term)
            0: queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_CR, 1'b0);
            1: queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_LF, 1'b0);
            2:
            begin
                queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_CR, 1'b0);
                queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_LF, 1'b0);
            end
            default: ;
        endcase
    endtask

    // sender: a transaction is taken at an edge with valid high and stall low
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                buffer_op_outcome(op, rx_byte);
                accepted++;
            end
            calm = (queued - accepted) < CALM_TAIL;
            if ($urandom_range(0, 63) == 0)
            begin
                send_rate = $urandom_range(0, 3);
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_txns.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (pending_txns[0].drain && results_due.size() != 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 9) < send_rate)
                begin
                    send_gap = $urandom_range(0, 7);
                    in_valid <= 1'b0;
                end
                else
                begin
                    op       <= pending_txns[0].code;
                    rx_byte  <= pending_txns[0].ch;
                    in_valid <= 1'b1;
                    void'(pending_txns.pop_front());
                end
            end
        end
    end

    // receiver: checks each result against the oldest prediction
    always @(posedge clk)
    begin
        ring_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result: data 0x%02h valid_res %0b last %0b lines %0d",
                           data, valid_res, last, lines_count);
                    errors++;
                end
                else
                begin
                    want = results_due.pop_front();
                    checked++;
                    if (data !== want.data)
                    begin
                        $error("data: expected 0x%02h, got 0x%02h", want.data, data);
                        errors++;
                    end
                    if (valid_res !== want.valid_res)
                    begin
                        $error("valid_res: expected %0b, got %0b", want.valid_res, valid_res);
                        errors++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, last);
                        errors++;
                    end
                    if (lines_count !== want.lines_count)
                    begin
                        $error("lines_count: expected %0d, got %0d",
                               want.lines_count, lines_count);
                        errors++;
                    end
                end
            end
            if ($urandom_range(0, 63) == 0)
            begin
                stall_rate = $urandom_range(0, 3);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 9) < stall_rate)
            begin
                stall_left = $urandom_range(0, 7);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int pick;
        // empty ring and nothing pending
        queue_txn(uartrx_pkg::OP_BYTE, 8'hff, 1'b0);
        queue_txn(uartrx_pkg::OP_LINE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_DISCARD, 8'h55, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h41, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h7f, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h01, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_CR, 1'b0);
        // repeated newline in both spellings is dropped
        queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_LF, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_CR, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'hff, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h80, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h42, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_LF, 1'b0);
        queue_txn(uartrx_pkg::OP_LINE, 8'haa, 1'b1);
        // high byte ends this line at once
        queue_txn(uartrx_pkg::OP_LINE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_BYTE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_BYTE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_BYTE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_BYTE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, 8'h78, 1'b0);
        queue_txn(uartrx_pkg::OP_RECV, uartrx_pkg::CHAR_LF, 1'b0);
        queue_txn(uartrx_pkg::OP_DISCARD, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_BYTE, 8'h00, 1'b0);
        // line still counted though the ring is empty
        queue_txn(uartrx_pkg::OP_LINE, 8'h00, 1'b1);

        // long line: full ring, overrun and the capped read
        queue_text_line(40, 1);
        queue_txn(uartrx_pkg::OP_LINE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_LINE, 8'h00, 1'b0);
        queue_txn(uartrx_pkg::OP_BYTE, 8'h00, 1'b0);

        while (queued < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 19);
            if (pick <= 8)
            begin
                queue_text_line(($urandom_range(0, 9) == 0) ? $urandom_range(25, 45)
                                                             : $urandom_range(0, 10),
                                $urandom_range(0, 3));
            end
            else if (pick <= 13)
            begin
                queue_txn(uartrx_pkg::OP_LINE,
                          uartrx_pkg::BYTE_W'($urandom_range(0, 255)),
                          $urandom_range(0, 39) == 0);
            end
            else if (pick <= 15)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    queue_txn(uartrx_pkg::OP_BYTE,
                              uartrx_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
                end
            end
            else if (pick == 16)
            begin
                queue_txn(uartrx_pkg::OP_DISCARD,
                          uartrx_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0);
            end
            else
            begin
                queue_txn(2'($urandom_range(0, 3)),
                          uartrx_pkg::BYTE_W'($urandom_range(0, 255)),
                          $urandom_range(0, 39) == 0);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted < queued)
        begin
            @(posedge clk);
        end
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("%0d transactions, %0d results checked, %0d lines read",
                 accepted, checked, lines_read);
        $display("ring filled %0d times, %0d overrun writes", ring_full_hits, overruns);
        if (errors == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/uartrx_pkg.sv
hdl/uartrx_ram.sv
hdl/uart_rx_line_ring_buffer.sv
tb/tb_uart_rx_line_ring_buffer.sv
